>>> sv/qrv_pkg.sv
// Shared types, pipeline depths and mixing tables for the quaternion rotate core.
// Used by every module of the block; depends on nothing.
`default_nettype none

package qrv_pkg;

    localparam int NORM_STEPS  = 5;
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 31;
    localparam int DIV_LAT     = DIV_STAGES + 1;

    // quaternion component order: x, y, z, w
    localparam int QX = 0;
    localparam int QY = 1;
    localparam int QZ = 2;
    localparam int QW = 3;

    // product t = q * v, order w, x, y, z (48-bit Q32.16 plus sign)
    typedef struct packed {
        logic [3:0][48:0] t;
        logic [3:0][31:0] qabs;
        logic [3:0]       qneg;
        logic [4:0]       e;
        logic             zero;
        logic             big;
    } t_norm;

    typedef struct packed {
        logic [3:0][48:0] t;
        logic [3:0]       qneg;
        logic             zero;
    } t_post;

    // which unit component multiplies each t term, per output axis
    localparam logic [1:0] MIX_SEL [0:2][0:3] = '{
        '{2'(QX), 2'(QW), 2'(QZ), 2'(QY)},
        '{2'(QY), 2'(QZ), 2'(QW), 2'(QX)},
        '{2'(QZ), 2'(QY), 2'(QX), 2'(QW)}
    };
    // conjugate sign per term
    localparam logic MIX_NEG [0:2][0:3] = '{
        '{1'b1, 1'b0, 1'b1, 1'b0},
        '{1'b1, 1'b0, 1'b0, 1'b1},
        '{1'b1, 1'b1, 1'b0, 1'b0}
    };

endpackage

`default_nettype wire

>>> sv/qrv_front.sv
// Front end: q*v products with rounding, sum of squares, radicand normalization.
// Depends on qrv_pkg.
`default_nettype none

module qrv_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [3:0][31:0]  i_q,
    input  wire logic [2:0][31:0]  i_v,
    output logic                   o_valid,
    output qrv_pkg::t_norm         o_side,
    output logic [63:0]            o_rad
);

    logic signed [31:0] qx, qy, qz, qw, vx, vy, vz;
    assign qx = i_q[qrv_pkg::QX];
    assign qy = i_q[qrv_pkg::QY];
    assign qz = i_q[qrv_pkg::QZ];
    assign qw = i_q[qrv_pkg::QW];
    assign vx = i_v[0];
    assign vy = i_v[1];
    assign vz = i_v[2];

    logic               r1_v;
    logic signed [63:0] r1_p  [0:11];
    logic signed [63:0] r1_sq [0:3];
    logic [3:0][31:0]   r1_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
        if (i_en) begin
            r1_p[0]  <= qw * vx;
            r1_p[1]  <= qy * vz;
            r1_p[2]  <= qz * vy;
            r1_p[3]  <= qw * vy;
            r1_p[4]  <= qz * vx;
            r1_p[5]  <= qx * vz;
            r1_p[6]  <= qw * vz;
            r1_p[7]  <= qx * vy;
            r1_p[8]  <= qy * vx;
            r1_p[9]  <= qx * vx;
            r1_p[10] <= qy * vy;
            r1_p[11] <= qz * vz;
            r1_sq[0] <= qx * qx;
            r1_sq[1] <= qy * qy;
            r1_sq[2] <= qz * qz;
            r1_sq[3] <= qw * qw;
            r1_q     <= i_q;
        end
    end

    // exact sums, rounded half up to Q.16; t order w, x, y, z
    logic signed [65:0] n_p [0:3];
    logic [3:0][48:0]   n_t;
    logic [64:0]        n_s;
    logic [3:0][31:0]   n_qabs;
    logic [3:0]         n_qneg;

    always_comb begin
        n_p[0] = -66'(r1_p[9]) - 66'(r1_p[10]) - 66'(r1_p[11]);
        n_p[1] = 66'(r1_p[0]) + 66'(r1_p[1]) - 66'(r1_p[2]);
        n_p[2] = 66'(r1_p[3]) + 66'(r1_p[4]) - 66'(r1_p[5]);
        n_p[3] = 66'(r1_p[6]) + 66'(r1_p[7]) - 66'(r1_p[8]);
        for (int k = 0; k < 4; k++) begin
            n_t[k]    = 49'((n_p[k] + 66'sd32768) >>> 16);
            n_qneg[k] = r1_q[k][31];
            n_qabs[k] = r1_q[k][31] ? (~r1_q[k] + 32'd1) : r1_q[k];
        end
        n_s = 65'($unsigned(r1_sq[0])) + 65'($unsigned(r1_sq[1]))
            + 65'($unsigned(r1_sq[2])) + 65'($unsigned(r1_sq[3]));
    end

    logic                   r_nv    [0:qrv_pkg::NORM_STEPS];
    logic [63:0]            r_nx    [0:qrv_pkg::NORM_STEPS];
    qrv_pkg::t_norm         r_nside [0:qrv_pkg::NORM_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nv[0] <= 1'b0;
        end else if (i_en) begin
            r_nv[0] <= r1_v;
        end
        if (i_en) begin
            r_nx[0]         <= n_s[63:0];
            r_nside[0].t    <= n_t;
            r_nside[0].qabs <= n_qabs;
            r_nside[0].qneg <= n_qneg;
            r_nside[0].e    <= '0;
            r_nside[0].zero <= (n_s == '0);
            r_nside[0].big  <= n_s[64];
        end
    end

    // bring the radicand into [2^62, 2^64) with even shifts
    for (genvar k = 0; k < qrv_pkg::NORM_STEPS; k++) begin : g_norm
        localparam int SH = 32 >> k;
        logic [63:0]    n_x;
        logic [4:0]     n_e;
        qrv_pkg::t_norm n_side;

        always_comb begin
            n_x = r_nx[k];
            n_e = r_nside[k].e;
            if (r_nx[k][63 -: SH] == '0) begin
                n_x = r_nx[k] << SH;
                n_e = r_nside[k].e + 5'(SH / 2);
            end
            n_side   = r_nside[k];
            n_side.e = n_e;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_nv[k+1] <= 1'b0;
            end else if (i_en) begin
                r_nv[k+1] <= r_nv[k];
            end
            if (i_en) begin
                r_nx[k+1]    <= n_x;
                r_nside[k+1] <= n_side;
            end
        end
    end

    assign o_valid = r_nv[qrv_pkg::NORM_STEPS];
    assign o_rad   = r_nx[qrv_pkg::NORM_STEPS];

    always_comb begin
        o_side = r_nside[qrv_pkg::NORM_STEPS];
        if (o_side.big) begin
            o_side.e = '0;
        end
    end

endmodule

`default_nettype wire

>>> sv/qrv_sqrt.sv
// Pipelined integer square root, one root bit per stage.
// Depends on qrv_pkg.
`default_nettype none

module qrv_sqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic [63:0] i_rad,
    output logic             o_valid,
    output logic [31:0]      o_root
);

    localparam int N = qrv_pkg::SQRT_STAGES;

    logic        r_v    [0:N-1];
    logic [63:0] r_rad  [0:N-1];
    logic [34:0] r_rem  [0:N-1];
    logic [31:0] r_root [0:N-1];

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic        in_v;
        logic [63:0] in_rad;
        logic [34:0] in_rem;
        logic [31:0] in_root;
        logic [34:0] cur, trial, n_rem;
        logic [31:0] n_root;

        if (s == 0) begin : g_first
            assign in_v    = i_valid;
            assign in_rad  = i_rad;
            assign in_rem  = '0;
            assign in_root = '0;
        end else begin : g_next
            assign in_v    = r_v[s-1];
            assign in_rad  = r_rad[s-1];
            assign in_rem  = r_rem[s-1];
            assign in_root = r_root[s-1];
        end

        always_comb begin
            cur   = {in_rem[32:0], in_rad[63-2*s -: 2]};
            trial = {1'b0, in_root, 2'b01};
            if (cur >= trial) begin
                n_rem  = cur - trial;
                n_root = {in_root[30:0], 1'b1};
            end else begin
                n_rem  = cur;
                n_root = {in_root[30:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= in_v;
            end
            if (i_en) begin
                r_rad[s]  <= in_rad;
                r_rem[s]  <= n_rem;
                r_root[s] <= n_root;
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_root  = r_root[N-1];

endmodule

`default_nettype wire

>>> sv/qrv_div.sv
// Pipelined restoring divider, rounded quotient round(num * 2^30 / den).
// Depends on qrv_pkg.
`default_nettype none

module qrv_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic [32:0] i_num,
    input  wire logic [32:0] i_den,
    output logic             o_valid,
    output logic [30:0]      o_quot
);

    localparam int N = qrv_pkg::DIV_STAGES;

    // dividend with half divisor added for round-half-away
    logic [62:0] n_dvd;
    assign n_dvd = {i_num, 30'b0} + 63'(i_den >> 1);

    logic        r_pv;
    logic [32:0] r_prem;
    logic [30:0] r_plow;
    logic [32:0] r_pden;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (i_en) begin
            r_pv <= i_valid;
        end
        if (i_en) begin
            r_prem <= {1'b0, n_dvd[62:31]};
            r_plow <= n_dvd[30:0];
            r_pden <= i_den;
        end
    end

    logic        r_v    [0:N-1];
    logic [32:0] r_rem  [0:N-1];
    logic [30:0] r_low  [0:N-1];
    logic [32:0] r_den  [0:N-1];
    logic [30:0] r_quot [0:N-1];

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic        in_v;
        logic [32:0] in_rem;
        logic [30:0] in_low;
        logic [32:0] in_den;
        logic [30:0] in_quot;
        logic [33:0] cur, den_x;
        logic [32:0] n_rem;
        logic        qbit;

        if (s == 0) begin : g_first
            assign in_v    = r_pv;
            assign in_rem  = r_prem;
            assign in_low  = r_plow;
            assign in_den  = r_pden;
            assign in_quot = '0;
        end else begin : g_next
            assign in_v    = r_v[s-1];
            assign in_rem  = r_rem[s-1];
            assign in_low  = r_low[s-1];
            assign in_den  = r_den[s-1];
            assign in_quot = r_quot[s-1];
        end

        always_comb begin
            cur   = {in_rem, in_low[N-1-s]};
            den_x = {1'b0, in_den};
            if (cur >= den_x) begin
                n_rem = 33'(cur - den_x);
                qbit  = 1'b1;
            end else begin
                n_rem = cur[32:0];
                qbit  = 1'b0;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= in_v;
            end
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_low[s]  <= in_low;
                r_den[s]  <= in_den;
                r_quot[s] <= {in_quot[29:0], qbit};
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_quot  = r_quot[N-1];

endmodule

`default_nettype wire

>>> sv/qrv_mix.sv
// Final Hamilton product t * conj(n): split products, sums, rounding, saturation.
// Depends on qrv_pkg; its last stage is the output register.
`default_nettype none

module qrv_mix (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [3:0][48:0] i_t,
    input  wire logic [3:0][31:0] i_n,
    input  wire logic             i_zero,
    output logic                  o_valid,
    output logic [2:0][31:0]      o_rot,
    output logic                  o_zero,
    output logic                  o_sat
);

    // stage 1: t split at bit 24, each half times a unit component
    logic               r1_v, r1_zero;
    logic signed [56:0] r1_ph [0:2][0:3];
    logic signed [56:0] r1_pl [0:2][0:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
        if (i_en) begin
            r1_zero <= i_zero;
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 4; k++) begin
                    r1_ph[j][k] <= $signed(i_t[k][48:24])
                                 * $signed(i_n[qrv_pkg::MIX_SEL[j][k]]);
                    r1_pl[j][k] <= $signed({1'b0, i_t[k][23:0]})
                                 * $signed(i_n[qrv_pkg::MIX_SEL[j][k]]);
                end
            end
        end
    end

    // stage 2: signed sums of the halves
    logic signed [58:0] n_h [0:2];
    logic signed [58:0] n_l [0:2];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_h[j] = '0;
            n_l[j] = '0;
            for (int k = 0; k < 4; k++) begin
                if (qrv_pkg::MIX_NEG[j][k]) begin
                    n_h[j] = n_h[j] - 59'(r1_ph[j][k]);
                    n_l[j] = n_l[j] - 59'(r1_pl[j][k]);
                end else begin
                    n_h[j] = n_h[j] + 59'(r1_ph[j][k]);
                    n_l[j] = n_l[j] + 59'(r1_pl[j][k]);
                end
            end
        end
    end

    logic               r2_v, r2_zero;
    logic signed [58:0] r2_h [0:2];
    logic signed [58:0] r2_l [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
        if (i_en) begin
            r2_zero <= r1_zero;
            for (int j = 0; j < 3; j++) begin
                r2_h[j] <= n_h[j];
                r2_l[j] <= n_l[j];
            end
        end
    end

    // stage 3: recombine, round half up to Q.16
    logic signed [82:0] n_tot [0:2];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_tot[j] = (83'(r2_h[j]) <<< 24) + 83'(r2_l[j]) + 83'sd536870912;
        end
    end

    logic               r3_v, r3_zero;
    logic signed [52:0] r3_res [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_en) begin
            r3_v <= r2_v;
        end
        if (i_en) begin
            r3_zero <= r2_zero;
            for (int j = 0; j < 3; j++) begin
                r3_res[j] <= 53'(n_tot[j] >>> 30);
            end
        end
    end

    // stage 4: clamp into the output register
    logic [2:0][31:0] n_rot;
    logic             n_sat;

    always_comb begin
        n_sat = 1'b0;
        for (int j = 0; j < 3; j++) begin
            if (r3_res[j] > 53'sd2147483647) begin
                n_rot[j] = 32'h7FFF_FFFF;
                n_sat    = 1'b1;
            end else if (r3_res[j] < -53'sd2147483648) begin
                n_rot[j] = 32'h8000_0000;
                n_sat    = 1'b1;
            end else begin
                n_rot[j] = r3_res[j][31:0];
            end
        end
    end

    logic             r_ov, r_ozero, r_osat;
    logic [2:0][31:0] r_orot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r3_v;
        end
        if (i_en) begin
            r_orot  <= n_rot;
            r_osat  <= n_sat;
            r_ozero <= r3_zero;
        end
    end

    assign o_valid = r_ov;
    assign o_rot   = r_orot;
    assign o_zero  = r_ozero;
    assign o_sat   = r_osat;

endmodule

`default_nettype wire

>>> sv/quaternion_rotate_vector_core.sv
// Quaternion vector rotation core: front end, square root, four dividers, mixer.
// Sustains one item per cycle while the output is not stalled.
// Depth: 7 front (products, sums, 5 normalize steps), 32 root bits, 32 divider
// (1 prep + 31 quotient bits), 1 sign, 4 mixer. Whole pipe holds while o_valid
// is stalled. Synchronous active-low reset clears valid bits only.
`default_nettype none

module quaternion_rotate_vector_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_quat_x,
    input  wire logic [31:0] i_quat_y,
    input  wire logic [31:0] i_quat_z,
    input  wire logic [31:0] i_quat_w,
    input  wire logic [31:0] i_vec_x,
    input  wire logic [31:0] i_vec_y,
    input  wire logic [31:0] i_vec_z,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_rot_x,
    output logic [31:0]      o_rot_y,
    output logic [31:0]      o_rot_z,
    output logic             o_zero_magnitude,
    output logic             o_saturated
);

    // pipeline advances unless a finished item is held at the output
    logic adv;
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    // front end: t = q*v, |q|^2, normalized radicand and shift e
    logic              f_valid;
    qrv_pkg::t_norm    f_side;
    logic [63:0]       f_rad;

    qrv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_valid),
        .i_q     ({i_quat_w, i_quat_z, i_quat_y, i_quat_x}),
        .i_v     ({i_vec_z, i_vec_y, i_vec_x}),
        .o_valid (f_valid),
        .o_side  (f_side),
        .o_rad   (f_rad)
    );

    // m = floor(sqrt(S * 4^e))
    logic        s_valid;
    logic [31:0] s_root;

    qrv_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (f_valid),
        .i_rad   (f_rad),
        .o_valid (s_valid),
        .o_root  (s_root)
    );

    // sideband rides alongside the root pipeline
    qrv_pkg::t_norm r_sq_side [0:qrv_pkg::SQRT_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq_side[0] <= f_side;
            for (int i = 1; i < qrv_pkg::SQRT_STAGES; i++) begin
                r_sq_side[i] <= r_sq_side[i-1];
            end
        end
    end

    qrv_pkg::t_norm d_side;
    assign d_side = r_sq_side[qrv_pkg::SQRT_STAGES-1];

    // all-components-at-minimum case: S = 2^64, root is exactly 2^32
    logic [32:0] mag;
    assign mag = d_side.big ? 33'h1_0000_0000 : {1'b0, s_root};

    // unit components |q_i| * 2^(30+e) / m, one divider per component
    logic [3:0]       dv_valid;
    logic [3:0][30:0] dv_quot;

    for (genvar i = 0; i < 4; i++) begin : g_div
        logic [32:0] num;
        assign num = {1'b0, d_side.qabs[i]} << d_side.e;

        qrv_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (s_valid),
            .i_num   (num),
            .i_den   (mag),
            .o_valid (dv_valid[i]),
            .o_quot  (dv_quot[i])
        );
    end

    qrv_pkg::t_post r_dv_side [0:qrv_pkg::DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dv_side[0].t    <= d_side.t;
            r_dv_side[0].qneg <= d_side.qneg;
            r_dv_side[0].zero <= d_side.zero;
            for (int i = 1; i < qrv_pkg::DIV_LAT; i++) begin
                r_dv_side[i] <= r_dv_side[i-1];
            end
        end
    end

    qrv_pkg::t_post p_side;
    assign p_side = r_dv_side[qrv_pkg::DIV_LAT-1];

    // sign stage: restore component signs; zero quaternion gives zero unit
    logic [3:0][31:0] n_unit;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (p_side.zero) begin
                n_unit[i] = '0;
            end else if (p_side.qneg[i]) begin
                n_unit[i] = -{1'b0, dv_quot[i]};
            end else begin
                n_unit[i] = {1'b0, dv_quot[i]};
            end
        end
    end

    logic             r_uv, r_uzero;
    logic [3:0][31:0] r_unit;
    logic [3:0][48:0] r_ut;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uv <= 1'b0;
        end else if (adv) begin
            r_uv <= &dv_valid;
        end
        if (adv) begin
            r_unit  <= n_unit;
            r_ut    <= p_side.t;
            r_uzero <= p_side.zero;
        end
    end

    // vector part of t * conj(unit), rounded and clamped
    logic [2:0][31:0] rot;

    qrv_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_uv),
        .i_t     (r_ut),
        .i_n     (r_unit),
        .i_zero  (r_uzero),
        .o_valid (o_valid),
        .o_rot   (rot),
        .o_zero  (o_zero_magnitude),
        .o_sat   (o_saturated)
    );

    assign o_rot_x = rot[0];
    assign o_rot_y = rot[1];
    assign o_rot_z = rot[2];

endmodule

`default_nettype wire
